// ===== rtl/bmcm_pkg.sv =====
// Shared constants, types and codes of the bone matrix chain multiplier.
`default_nettype none
package bmcm_pkg;
	localparam int MAX_BONES = 64;
	localparam int FRAC_BITS = 16;
	localparam int BONE_W = 6;
	localparam int PAR_W = 7;
	localparam int ELEM_W = 32;
	localparam int BCNT_W = 7;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam int BIDX_W = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
	localparam int ROW_AW = BIDX_W + 2;
	localparam int ROWS = MAX_BONES * 4;
	localparam int PROD_W = 2 * ELEM_W;
	localparam int SHP_W = PROD_W - FRAC_BITS;
	localparam int ACC_W = SHP_W + 2;
	localparam logic [BCNT_W-1:0] BONE_COUNT_RST = 7'd64;
	localparam logic REG_BONE_COUNT = 1'b0;

	typedef logic signed [ELEM_W-1:0] elem_t;
	typedef elem_t [3:0] row_t;

	typedef enum logic {
		CMD_LOAD  = 1'b0,
		CMD_LOCAL = 1'b1
	} cmd_t;

	typedef struct packed {
		logic       vld;
		logic       ph2;
		logic [1:0] r;
		logic [1:0] k;
	} step_t;

	typedef struct packed {
		logic [BONE_W-1:0] bone;
		logic [1:0]        row;
		row_t              data;
		logic              last_row;
		logic              frame_end;
		logic              bad_parent;
	} res_t;
endpackage
`default_nettype wire

// ===== rtl/bmcm_if.sv =====
// Item channels of the bone matrix chain multiplier.
`default_nettype none
interface bmcm_in_if;
	logic              valid;
	logic              ready;
	logic              command;
	logic [5:0]        bone;
	logic signed [6:0] parent;
	logic [1:0]        row;
	logic signed [31:0] elem0;
	logic signed [31:0] elem1;
	logic signed [31:0] elem2;
	logic signed [31:0] elem3;
	modport source (output valid, command, bone, parent, row, elem0, elem1, elem2, elem3,
		input ready);
	modport sink (input valid, command, bone, parent, row, elem0, elem1, elem2, elem3,
		output ready);
endinterface

interface bmcm_out_if;
	logic               valid;
	logic               ready;
	logic [5:0]         out_bone;
	logic [1:0]         out_row;
	logic signed [31:0] out_elem0;
	logic signed [31:0] out_elem1;
	logic signed [31:0] out_elem2;
	logic signed [31:0] out_elem3;
	logic               last_row;
	logic               frame_end;
	logic               bad_parent;
	modport source (output valid, out_bone, out_row, out_elem0, out_elem1, out_elem2,
		out_elem3, last_row, frame_end, bad_parent, input ready);
	modport sink (input valid, out_bone, out_row, out_elem0, out_elem1, out_elem2,
		out_elem3, last_row, frame_end, bad_parent, output ready);
endinterface
`default_nettype wire

// ===== rtl/bone_matrix_chain_multiply.sv =====
// Top level of the bone matrix chain multiplier.
// rows: input items. command 0 stores one inverse-bind row of a bone and its
// parent; command 1 buffers one local-transform row. The item that completes
// all four local rows starts the bone's work: global = parent global * local
// (or local for a root or a bad parent), then four result items of
// global * inverse-bind, rows 0..3, on the results channel.
// Each of the four lanes has one multiplier; each result row takes four
// lane steps, so a bone costs 16 steps per product. Load items and the
// first three local rows are taken at one per cycle while rows.ready is high.
// rows.ready is low while a bone is in work; the global and inverse-bind
// memories (one row read per cycle) set the pace.
// The second product waits until the four-entry result queue is empty, so a
// stalled receiver holds the block only at that point.
// Reset clears the control state and sets bone_count to 64; memories hold
// nothing defined until written. Configuration is over APB at address 0.
`default_nettype none
module bone_matrix_chain_multiply (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	bmcm_in_if.sink                          rows,
	bmcm_out_if.source                       results,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [bmcm_pkg::ADDR_W-1:0] paddr,
	input  wire logic [bmcm_pkg::DATA_W-1:0] pwdata,
	output logic      [bmcm_pkg::DATA_W-1:0] prdata,
	output logic                             pready
);
	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_PAR   = 7'b0000010,
		S_COPY  = 7'b0000100,
		S_MUL1  = 7'b0001000,
		S_WAIT  = 7'b0010000,
		S_MUL2  = 7'b0100000,
		S_DRAIN = 7'b1000000
	} state_t;

	state_t                               st_q;
	logic [3:0]                           cnt_q;
	logic [3:0]                           seen_q;
	logic [3:0]                           seen_nxt;
	logic [bmcm_pkg::BONE_W-1:0]          bone_q;
	logic [bmcm_pkg::BONE_W-1:0]          pidx_q;
	logic                                 bad_q;
	logic                                 bad;
	logic                                 root;
	logic [bmcm_pkg::BCNT_W-1:0]          bone_count;
	logic                                 accept;
	logic                                 in_ok;
	logic                                 ld;
	logic                                 lc;
	logic                                 fire;
	logic                                 issue;
	logic                                 busy;
	logic                                 outq_empty;
	logic                                 push;
	bmcm_pkg::res_t                       res_in;
	bmcm_pkg::row_t                       row_in;
	bmcm_pkg::row_t                       loc_q [4];
	bmcm_pkg::row_t                       g_q [4];
	bmcm_pkg::row_t                       inv_mem [bmcm_pkg::ROWS];
	bmcm_pkg::row_t                       glob_mem [bmcm_pkg::ROWS];
	logic signed [bmcm_pkg::PAR_W-1:0]    par_mem [bmcm_pkg::MAX_BONES];
	logic signed [bmcm_pkg::PAR_W-1:0]    par_rd_q;
	bmcm_pkg::row_t                       inv_rd_q;
	bmcm_pkg::row_t                       glob_rd_q;
	logic [bmcm_pkg::ROW_AW-1:0]          ld_addr;
	logic [bmcm_pkg::ROW_AW-1:0]          inv_raddr;
	logic [bmcm_pkg::ROW_AW-1:0]          glob_raddr;
	logic [bmcm_pkg::ROW_AW-1:0]          glob_waddr;
	logic                                 glob_we;
	logic [1:0]                           g_wrow;
	bmcm_pkg::row_t                       glob_wdata;
	bmcm_pkg::step_t                      ctrl_s1;
	bmcm_pkg::step_t                      ctrl_s2;
	bmcm_pkg::step_t                      ctrl_s3;
	bmcm_pkg::step_t                      ctrl_s4;
	bmcm_pkg::elem_t                      a_s2;
	bmcm_pkg::row_t                       b_s2;
	bmcm_pkg::row_t                       res_row;
	logic                                 copy;
	logic                                 s4_g;

	bmcm_apb u_apb (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.bone_count (bone_count)
	);

	assign rows.ready = st_q == S_IDLE;
	assign accept = rows.valid && rows.ready;
	assign in_ok = 9'(rows.bone) < 9'(bmcm_pkg::MAX_BONES);
	assign ld = accept && in_ok && rows.command == bmcm_pkg::CMD_LOAD;
	assign lc = accept && in_ok && rows.command == bmcm_pkg::CMD_LOCAL;
	assign seen_nxt = seen_q | (4'(1) << rows.row);
	assign fire = lc && (&seen_nxt);
	assign row_in = {rows.elem3, rows.elem2, rows.elem1, rows.elem0};
	assign ld_addr = bmcm_pkg::ROW_AW'({rows.bone, rows.row});

	assign bad = !par_rd_q[bmcm_pkg::PAR_W-1]
		&& (par_rd_q[bmcm_pkg::PAR_W-2:0] >= bone_q);
	assign root = par_rd_q[bmcm_pkg::PAR_W-1] || bad;

	assign issue = (st_q == S_MUL1) || (st_q == S_MUL2);
	assign busy = ctrl_s1.vld || ctrl_s2.vld || ctrl_s3.vld || ctrl_s4.vld;
	assign inv_raddr = bmcm_pkg::ROW_AW'({bone_q, cnt_q[1:0]});
	assign glob_raddr = bmcm_pkg::ROW_AW'({pidx_q, cnt_q[3:2]});

	assign copy = st_q == S_COPY;
	assign s4_g = ctrl_s4.vld && !ctrl_s4.ph2;
	assign glob_we = copy || s4_g;
	assign g_wrow = copy ? cnt_q[1:0] : ctrl_s4.r;
	assign glob_waddr = bmcm_pkg::ROW_AW'({bone_q, g_wrow});
	assign glob_wdata = copy ? loc_q[cnt_q[1:0]] : res_row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			cnt_q <= '0;
			seen_q <= '0;
		end else begin
			if (lc) begin
				seen_q <= fire ? 4'd0 : seen_nxt;
			end
			unique case (st_q)
				S_IDLE: begin
					if (fire) begin
						st_q <= S_PAR;
					end
				end
				S_PAR: begin
					cnt_q <= '0;
					st_q <= root ? S_COPY : S_MUL1;
				end
				S_COPY: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q[1:0] == 2'd3) begin
						st_q <= S_WAIT;
					end
				end
				S_MUL1: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd15) begin
						st_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					cnt_q <= '0;
					if (outq_empty) begin
						st_q <= S_MUL2;
					end
				end
				S_MUL2: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd15) begin
						st_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (!busy) begin
						st_q <= S_IDLE;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (lc) begin
			loc_q[rows.row] <= row_in;
		end
		if (fire) begin
			bone_q <= rows.bone;
		end
		if (st_q == S_PAR) begin
			bad_q <= bad;
			pidx_q <= par_rd_q[bmcm_pkg::BONE_W-1:0];
		end
		if (glob_we) begin
			g_q[g_wrow] <= glob_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			inv_mem[ld_addr] <= row_in;
			par_mem[bmcm_pkg::BIDX_W'(rows.bone)] <= rows.parent;
		end
		par_rd_q <= par_mem[bmcm_pkg::BIDX_W'(rows.bone)];
		inv_rd_q <= inv_mem[inv_raddr];
	end

	always_ff @(posedge clk) begin
		if (glob_we) begin
			glob_mem[glob_waddr] <= glob_wdata;
		end
		glob_rd_q <= glob_mem[glob_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
			ctrl_s2 <= '0;
			ctrl_s3 <= '0;
			ctrl_s4 <= '0;
		end else begin
			ctrl_s1 <= '{vld: issue, ph2: st_q == S_MUL2, r: cnt_q[3:2], k: cnt_q[1:0]};
			ctrl_s2 <= ctrl_s1;
			ctrl_s3 <= ctrl_s2;
			ctrl_s4 <= '{vld: ctrl_s3.vld && ctrl_s3.k == 2'd3, ph2: ctrl_s3.ph2,
				r: ctrl_s3.r, k: ctrl_s3.k};
		end
	end

	always_ff @(posedge clk) begin
		a_s2 <= ctrl_s1.ph2 ? g_q[ctrl_s1.r][ctrl_s1.k] : glob_rd_q[ctrl_s1.k];
		b_s2 <= ctrl_s1.ph2 ? inv_rd_q : loc_q[ctrl_s1.k];
	end

	for (genvar c = 0; c < 4; c++) begin : g_lane
		bmcm_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.step   (ctrl_s2),
			.a      (a_s2),
			.b      (b_s2[c]),
			.res    (res_row[c])
		);
	end

	assign push = ctrl_s4.vld && ctrl_s4.ph2;
	assign res_in = '{
		bone:       bone_q,
		row:        ctrl_s4.r,
		data:       res_row,
		last_row:   ctrl_s4.r == 2'd3,
		frame_end:  (ctrl_s4.r == 2'd3)
			&& (8'(bone_q) + 8'd1 == 8'(bone_count)),
		bad_parent: bad_q
	};

	bmcm_outq u_outq (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.din     (res_in),
		.empty   (outq_empty),
		.results (results)
	);

`ifndef ASSERT_OFF
	a_ready_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		rows.ready |-> !busy)
		else $error("item taken while lanes busy");
	a_push_in_mul2: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (st_q == S_MUL2 || st_q == S_DRAIN))
		else $error("result row outside second product");
	a_copy_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		copy |-> !busy)
		else $error("copy overlaps lane writes");
`endif
endmodule
`default_nettype wire

// ===== rtl/bmcm_apb.sv =====
// APB register file holding the bone count.
`default_nettype none
module bmcm_apb (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [bmcm_pkg::ADDR_W-1:0]     paddr,
	input  wire logic [bmcm_pkg::DATA_W-1:0]     pwdata,
	output logic      [bmcm_pkg::DATA_W-1:0]     prdata,
	output logic                                 pready,
	output logic      [bmcm_pkg::BCNT_W-1:0]     bone_count
);
	logic [bmcm_pkg::BCNT_W-1:0] bone_count_q;
	logic                        sel_bc;

	assign sel_bc = paddr[bmcm_pkg::ADDR_W-1:2] == bmcm_pkg::REG_BONE_COUNT;
	assign pready = 1'b1;
	assign bone_count = bone_count_q;
	assign prdata = sel_bc ? bmcm_pkg::DATA_W'(bone_count_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bone_count_q <= bmcm_pkg::BONE_COUNT_RST;
		end else if (psel && penable && pwrite && sel_bc) begin
			bone_count_q <= pwdata[bmcm_pkg::BCNT_W-1:0];
		end
	end
endmodule
`default_nettype wire

// ===== rtl/bmcm_lane.sv =====
// One multiply-accumulate lane: truncated Q products, exact sum, saturation.
`default_nettype none
module bmcm_lane (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire bmcm_pkg::step_t step,
	input  wire bmcm_pkg::elem_t a,
	input  wire bmcm_pkg::elem_t b,
	output bmcm_pkg::elem_t      res
);
	logic signed [bmcm_pkg::PROD_W-1:0] prod_s3;
	logic                               vld_s3;
	logic                               first_s3;
	logic                               last_s3;
	logic signed [bmcm_pkg::ACC_W-1:0]  acc_q;
	logic signed [bmcm_pkg::ACC_W-1:0]  shp;
	logic signed [bmcm_pkg::ACC_W-1:0]  base;
	logic signed [bmcm_pkg::ACC_W-1:0]  sum;
	bmcm_pkg::elem_t                    res_q;
	bmcm_pkg::elem_t                    sat;

	assign shp = bmcm_pkg::ACC_W'($signed(prod_s3[bmcm_pkg::PROD_W-1:bmcm_pkg::FRAC_BITS]));
	assign base = first_s3 ? bmcm_pkg::ACC_W'(0) : acc_q;
	assign sum = base + shp;

	always_comb begin
		if (sum[bmcm_pkg::ACC_W-1] && !(&sum[bmcm_pkg::ACC_W-2:bmcm_pkg::ELEM_W-1])) begin
			sat = {1'b1, {(bmcm_pkg::ELEM_W-1){1'b0}}};
		end else if (!sum[bmcm_pkg::ACC_W-1] && (|sum[bmcm_pkg::ACC_W-2:bmcm_pkg::ELEM_W-1])) begin
			sat = {1'b0, {(bmcm_pkg::ELEM_W-1){1'b1}}};
		end else begin
			sat = sum[bmcm_pkg::ELEM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= step.vld;
		end
	end

	always_ff @(posedge clk) begin
		prod_s3 <= bmcm_pkg::PROD_W'(a) * bmcm_pkg::PROD_W'(b);
		first_s3 <= step.k == 2'd0;
		last_s3 <= step.k == 2'd3;
		if (vld_s3) begin
			acc_q <= sum;
		end
		if (vld_s3 && last_s3) begin
			res_q <= sat;
		end
	end

	assign res = res_q;
endmodule
`default_nettype wire

// ===== rtl/bmcm_outq.sv =====
// Four-entry result queue between the lanes and the result channel.
`default_nettype none
module bmcm_outq (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire bmcm_pkg::res_t din,
	output logic                empty,
	bmcm_out_if.source          results
);
	bmcm_pkg::res_t ent_q [4];
	logic [1:0]     wp_q;
	logic [1:0]     rp_q;
	logic [2:0]     cnt_q;
	logic           pop;

	assign pop = results.valid && results.ready;
	assign empty = cnt_q == 3'd0;
	assign results.valid = !empty;
	assign results.out_bone = ent_q[rp_q].bone;
	assign results.out_row = ent_q[rp_q].row;
	assign results.out_elem0 = ent_q[rp_q].data[0];
	assign results.out_elem1 = ent_q[rp_q].data[1];
	assign results.out_elem2 = ent_q[rp_q].data[2];
	assign results.out_elem3 = ent_q[rp_q].data[3];
	assign results.last_row = ent_q[rp_q].last_row;
	assign results.frame_end = ent_q[rp_q].frame_end;
	assign results.bad_parent = ent_q[rp_q].bad_parent;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 2'd1;
			end
			if (pop) begin
				rp_q <= rp_q + 2'd1;
			end
			cnt_q <= cnt_q + 3'(push) - 3'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= din;
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (cnt_q != 3'd4 || pop))
		else $error("result queue overflow");
`endif
endmodule
`default_nettype wire

// ===== tb/bone_matrix_chain_multiply_test.sv =====
// Self-checking testbench of the bone matrix chain multiplier: predicts every result row.
`timescale 1ns / 1ps
module bone_matrix_chain_multiply_test;

	typedef logic signed [31:0] mat_t [16];

	typedef struct packed {
		logic              cmd;
		logic [5:0]        bone;
		logic signed [6:0] parent;
		logic [1:0]        row;
		logic [3:0][31:0]  e;
	} row_item_t;

	typedef struct packed {
		logic [5:0]       bone;
		logic [1:0]       row;
		logic [3:0][31:0] e;
		logic             last_row;
		logic             frame_end;
		logic             bad_parent;
	} pose_row_t;

	localparam int LIMIT = 400000;
	localparam int SETTLE = 60;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [bmcm_pkg::ADDR_W-1:0] paddr;
	logic [bmcm_pkg::DATA_W-1:0] pwdata;
	logic [bmcm_pkg::DATA_W-1:0] prdata;
	logic pready;

	bmcm_in_if rows_ch();
	bmcm_out_if res_ch();

	bone_matrix_chain_multiply dut (
		.clk(clk), .arst_n(arst_n), .rows(rows_ch), .results(res_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	row_item_t pending_rows[$];
	pose_row_t expected_pose[$];
	row_item_t cur_row;
	int errors = 0;
	int send_pct = 0;
	int recv_pct = 0;
	int cycles = 0;

	mat_t inv_bind [bmcm_pkg::MAX_BONES];
	mat_t global_mat [bmcm_pkg::MAX_BONES];
	mat_t local_mat;
	int parent_of [bmcm_pkg::MAX_BONES];
	logic [3:0] local_mask;
	logic [6:0] bone_count;

	logic [3:0] g_inv [bmcm_pkg::MAX_BONES];
	bit g_par_w [bmcm_pkg::MAX_BONES];
	int g_par [bmcm_pkg::MAX_BONES];
	bit g_glob [bmcm_pkg::MAX_BONES];
	logic [3:0] g_mask;

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("FAIL bone_matrix_chain_multiply");
			$finish;
		end
	end

	function automatic logic signed [31:0] sat32(longint v);
		if (v > 64'sd2147483647)
			return 32'sh7fffffff;
		if (v < -64'sd2147483648)
			return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic mat_t mat_product(mat_t a, mat_t b);
		mat_t c;
		longint acc;
		longint prod;
		for (int r = 0; r < 4; r++)
			for (int col = 0; col < 4; col++) begin
				acc = 0;
				for (int k = 0; k < 4; k++) begin
					prod = longint'(a[r*4+k]) * longint'(b[k*4+col]);
					acc += prod >>> bmcm_pkg::FRAC_BITS;
				end
				c[r*4+col] = sat32(acc);
			end
		return c;
	endfunction

	task automatic predict_pose(row_item_t it);
		int b;
		int p;
		bit bad;
		mat_t fin;
		pose_row_t pr;
		b = it.bone;
		if (it.cmd == bmcm_pkg::CMD_LOAD) begin
			for (int c = 0; c < 4; c++)
				inv_bind[b][it.row*4+c] = it.e[c];
			parent_of[b] = it.parent;
			return;
		end
		for (int c = 0; c < 4; c++)
			local_mat[it.row*4+c] = it.e[c];
		local_mask = local_mask | (4'b1 << it.row);
		if (local_mask != 4'hf)
			return;
		local_mask = '0;
		p = parent_of[b];
		bad = (p >= 0) && (p >= b);
		if (p < 0 || bad)
			global_mat[b] = local_mat;
		else
			global_mat[b] = mat_product(global_mat[p], local_mat);
		fin = mat_product(global_mat[b], inv_bind[b]);
		for (int k = 0; k < 4; k++) begin
			pr.bone = 6'(b);
			pr.row = 2'(k);
			for (int c = 0; c < 4; c++)
				pr.e[c] = fin[k*4+c];
			pr.last_row = (k == 3);
			pr.frame_end = (k == 3) && (b + 1 == int'(bone_count));
			pr.bad_parent = bad;
			expected_pose.push_back(pr);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		row_item_t nxt;
		logic go;
		if (!arst_n) begin
			rows_ch.valid <= 1'b0;
			rows_ch.command <= 1'b0;
			rows_ch.bone <= '0;
			rows_ch.parent <= '0;
			rows_ch.row <= '0;
			rows_ch.elem0 <= '0;
			rows_ch.elem1 <= '0;
			rows_ch.elem2 <= '0;
			rows_ch.elem3 <= '0;
		end else if (!rows_ch.valid || rows_ch.ready) begin
			if (rows_ch.valid)
				predict_pose(cur_row);
			go = (pending_rows.size() > 0) && ($urandom_range(0, 99) >= send_pct);
			if (go) begin
				nxt = pending_rows.pop_front();
				cur_row = nxt;
				rows_ch.command <= nxt.cmd;
				rows_ch.bone <= nxt.bone;
				rows_ch.parent <= nxt.parent;
				rows_ch.row <= nxt.row;
				rows_ch.elem0 <= nxt.e[0];
				rows_ch.elem1 <= nxt.e[1];
				rows_ch.elem2 <= nxt.e[2];
				rows_ch.elem3 <= nxt.e[3];
			end
			rows_ch.valid <= go;
		end
	end

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h expected %h", what, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		pose_row_t w;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (expected_pose.size() == 0) begin
					report("unexpected row, bone", 32'(res_ch.out_bone), 32'd0);
				end else begin
					w = expected_pose.pop_front();
					if (res_ch.out_bone !== w.bone)
						report("out_bone", 32'(res_ch.out_bone), 32'(w.bone));
					if (res_ch.out_row !== w.row)
						report("out_row", 32'(res_ch.out_row), 32'(w.row));
					if (res_ch.out_elem0 !== w.e[0]) report("out_elem0", res_ch.out_elem0, w.e[0]);
					if (res_ch.out_elem1 !== w.e[1]) report("out_elem1", res_ch.out_elem1, w.e[1]);
					if (res_ch.out_elem2 !== w.e[2]) report("out_elem2", res_ch.out_elem2, w.e[2]);
					if (res_ch.out_elem3 !== w.e[3]) report("out_elem3", res_ch.out_elem3, w.e[3]);
					if (res_ch.last_row !== w.last_row)
						report("last_row", 32'(res_ch.last_row), 32'(w.last_row));
					if (res_ch.frame_end !== w.frame_end)
						report("frame_end", 32'(res_ch.frame_end), 32'(w.frame_end));
					if (res_ch.bad_parent !== w.bad_parent)
						report("bad_parent", 32'(res_ch.bad_parent), 32'(w.bad_parent));
				end
			end
			res_ch.ready <= ($urandom_range(0, 99) >= recv_pct);
		end
	end

	function automatic logic [31:0] pick_elem(int mode);
		int sel;
		sel = $urandom_range(0, 3);
		if (mode == 1) begin
			case (sel)
				0: return 32'h80000000;
				1: return 32'h7fffffff;
				2: return 32'hffffffff;
				default: return 32'h00000000;
			endcase
		end
		if (sel < 2)
			return $urandom_range(0, 32'h3ffff) - 32'h20000;
		if (sel == 2)
			return $urandom;
		return pick_elem(1);
	endfunction

	task automatic add_row(logic cmd, int b, int p, int r, int mode);
		row_item_t it;
		it.cmd = cmd;
		it.bone = 6'(b);
		it.parent = 7'(p);
		it.row = 2'(r);
		for (int c = 0; c < 4; c++)
			it.e[c] = pick_elem(mode);
		pending_rows.push_back(it);
	endtask

	function automatic bit bone_ready(int b);
		int p;
		p = g_par[b];
		return g_inv[b] == 4'hf && g_par_w[b] && (p < 0 || p >= b || g_glob[p]);
	endfunction

	task automatic add_load(int b, int p, int r, int mode);
		add_row(bmcm_pkg::CMD_LOAD, b, p, r, mode);
		g_inv[b][r] = 1'b1;
		g_par_w[b] = 1;
		g_par[b] = p;
	endtask

	task automatic add_local(int b, int r, int mode);
		if ((g_mask | (4'b1 << r)) == 4'hf && !bone_ready(b)) begin
			for (int i = 3; i >= 0; i--)
				if (g_mask[i])
					r = i;
		end
		add_row(bmcm_pkg::CMD_LOCAL, b, $urandom_range(0, 127), r, mode);
		g_mask = g_mask | (4'b1 << r);
		if (g_mask == 4'hf) begin
			g_mask = '0;
			g_glob[b] = 1;
		end
	endtask

	task automatic add_bone(int b, int p, int mode);
		int s;
		s = $urandom_range(0, 3);
		for (int i = 0; i < 4; i++)
			add_load(b, p, (s + i) % 4, mode);
		s = $urandom_range(0, 3);
		for (int i = 0; i < 4; i++)
			add_local(b, (s + i) % 4, mode);
	endtask

	task automatic apb_write(logic [bmcm_pkg::ADDR_W-1:0] a, logic [bmcm_pkg::DATA_W-1:0] d);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= a;
		pwdata <= d;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic drain();
		while (pending_rows.size() > 0 || rows_ch.valid || expected_pose.size() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	initial begin
		int cfg_vals[6] = '{64, 1, 127, 0, 33, 64};
		int target;
		int b;
		int p;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = '0;
		pwdata = '0;
		local_mask = '0;
		bone_count = bmcm_pkg::BONE_COUNT_RST;
		g_mask = '0;
		for (int i = 0; i < bmcm_pkg::MAX_BONES; i++) begin
			g_inv[i] = '0;
			g_par_w[i] = 0;
			g_glob[i] = 0;
			parent_of[i] = 0;
		end
		arst_n = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		for (int ph = 0; ph < 6; ph++) begin
			send_pct = (ph < 2) ? 23 : (ph < 4) ? 86 : 0;
			recv_pct = (ph < 2) ? 86 : (ph < 4) ? 23 : 0;
			apb_write(bmcm_pkg::ADDR_W'(int'(bmcm_pkg::REG_BONE_COUNT) * 4),
				bmcm_pkg::DATA_W'(cfg_vals[ph]));
			bone_count = 7'(cfg_vals[ph]);
			if (ph == 0) begin
				add_bone(0, -1, 1);
				add_bone(1, 0, 1);
				add_bone(63, 63, 0);
			end
			target = pending_rows.size() + 48;
			while (pending_rows.size() < target) begin
				b = (ph == 5 || $urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
					: $urandom_range(0, 7);
				if ($urandom_range(0, 99) < 80) begin
					case ($urandom_range(0, 3))
						0: p = -1;
						1: p = $urandom_range(0, 127) - 64;
						2: p = $urandom_range(b, 63);
						default: p = (b > 0) ? $urandom_range(0, b - 1) : -1;
					endcase
					if (p >= 0 && p < b && !g_glob[p])
						p = -1;
					add_bone(b, p, 0);
				end else if ($urandom_range(0, 1) == 0) begin
					add_load(b, $urandom_range(0, 127) - 64, $urandom_range(0, 3), 0);
				end else begin
					add_local(b, $urandom_range(0, 3), 0);
				end
			end
			drain();
		end
		if (errors == 0)
			$display("PASS bone_matrix_chain_multiply");
		else
			$display("FAIL bone_matrix_chain_multiply");
		$finish;
	end
endmodule
